// ===== design/stt_pkg.sv =====
// Shared types, token codes and keyword tables for the source text tokenizer.
// No dependencies; every other file imports this package.
`default_nettype none

package stt_pkg;

    localparam int NAME_CHARS = 8;
    localparam int NUM_OPS    = 10;
    localparam int NUM_KWS    = 10;

    localparam logic [4:0] TOK_END    = 5'd0;
    localparam logic [4:0] TOK_CONST  = 5'd1;
    localparam logic [4:0] TOK_IDENT  = 5'd2;
    localparam logic [4:0] TOK_ASSIGN = 5'd9;
    localparam logic [4:0] TOK_EQ     = 5'd10;
    localparam logic [4:0] TOK_NE     = 5'd11;
    localparam logic [4:0] TOK_GT     = 5'd12;
    localparam logic [4:0] TOK_GE     = 5'd14;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_BADCHAR = 2'd1;
    localparam logic [1:0] ERR_DIGLET  = 2'd2;
    localparam logic [1:0] ERR_BANG    = 2'd3;

    localparam logic [30:0] MAX_VALUE = 31'h7FFF_FFFF;

    localparam logic [7:0] OP_CHARS [NUM_OPS] = '{
        8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h3B, 8'h2C
    };
    localparam logic [4:0] OP_CODES [NUM_OPS] = '{
        5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd16, 5'd17, 5'd24, 5'd29
    };

    // keyword text, first character in the low byte
    localparam logic [63:0] KW_TEXT [NUM_KWS] = '{
        64'h0000_0000_0000_6669,    // if
        64'h0000_0066_6964_6E65,    // endif
        64'h0000_0000_6573_6C65,    // else
        64'h0065_736C_6564_6E65,    // endelse
        64'h0000_0065_6C69_6877,    // while
        64'h656C_6968_7764_6E65,    // endwhile
        64'h0000_0000_6461_6572,    // read
        64'h0000_0065_7469_7277,    // write
        64'h0000_0000_0074_6E69,    // int
        64'h0000_0000_3174_6E69     // int1
    };
    localparam logic [7:0] KW_LEN [NUM_KWS] = '{
        8'd2, 8'd5, 8'd4, 8'd7, 8'd5, 8'd8, 8'd4, 8'd5, 8'd3, 8'd4
    };
    localparam logic [4:0] KW_CODE [NUM_KWS] = '{
        5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd25, 5'd26, 5'd27, 5'd28
    };

    typedef struct packed {
        logic [4:0]  token_code;
        logic [1:0]  error_code;
        logic [30:0] number_value;
        logic        value_overflow;
        logic [63:0] name_text;
        logic [7:0]  name_length;
        logic        name_truncated;
        logic [15:0] line_number;
        logic [15:0] column_number;
        logic        last_of_run;
    } t_token;

    typedef struct packed {
        logic   v0;
        logic   v1;
        t_token e0;
        t_token e1;
    } t_push;

    typedef struct packed {
        logic       hit;
        logic [4:0] code;
    } t_kw;

    function automatic t_token make_tok(input logic [4:0] code, input logic [1:0] err,
                                        input logic [15:0] line, input logic [15:0] col);
        t_token t;
        t = '0;
        t.token_code    = code;
        t.error_code    = err;
        t.line_number   = line;
        t.column_number = col;
        return t;
    endfunction

    function automatic t_kw kw_lookup(input logic [63:0] text, input logic [7:0] len);
        t_kw k;
        k = '0;
        for (int i = 0; i < NUM_KWS; i++) begin
            if (text == KW_TEXT[i] && len == KW_LEN[i]) begin
                k.hit  = 1'b1;
                k.code = KW_CODE[i];
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== design/stt_ifs.sv =====
// Valid/ready channel interfaces: source characters in, tokens out.
// Depends on stt_pkg for field widths.
`default_nettype none

interface stt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface stt_tok_if;
    import stt_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [4:0]              token_code;
    logic [1:0]              error_code;
    logic [30:0]             number_value;
    logic                    value_overflow;
    logic [8*NAME_CHARS-1:0] name_text;
    logic [7:0]              name_length;
    logic                    name_truncated;
    logic [15:0]             line_number;
    logic [15:0]             column_number;
    logic                    last_of_run;

    modport source (output valid, output token_code, output error_code,
                    output number_value, output value_overflow, output name_text,
                    output name_length, output name_truncated, output line_number,
                    output column_number, output last_of_run, input ready);
    modport sink   (input valid, input token_code, input error_code,
                    input number_value, input value_overflow, input name_text,
                    input name_length, input name_truncated, input line_number,
                    input column_number, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== design/stt_scanner.sv =====
// Front end: accepts characters, runs the scanner state machine, and pushes
// up to two finished tokens per beat into the queue. Uses stt_pkg, stt_char_if.
`default_nettype none

module stt_scanner
    import stt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    stt_char_if.sink  i_char,
    input  wire logic i_room,
    output t_push     o_push
);

    typedef enum logic [2:0] {
        M_START, M_IDENT, M_NUMBER, M_ASSIGN, M_BANG, M_REL, M_HALT
    } t_mode;

    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5A;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7A;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_NL   = 8'h0A;

    t_mode       r_mode, n_mode;
    logic        r_rel, n_rel;
    logic [63:0] r_buf, n_buf;
    logic [7:0]  r_cnt, n_cnt;
    logic [30:0] r_acc, n_acc;
    logic        r_ovf, n_ovf;
    logic [15:0] r_line, n_line;
    logic [15:0] r_col, n_col;
    t_push       n_push;
    logic        accept;

    assign i_char.ready = i_room;
    assign accept       = i_char.valid & i_room;

    always_comb begin
        logic [7:0]  c;
        logic        eot, is_let, is_dig, is_eq, is_op;
        logic [4:0]  op_code;
        logic [15:0] col_inc, line_inc;
        t_mode       st_mode;
        logic        st_v, st_name, st_num, st_rel;
        t_token      st_res;
        logic [15:0] st_line, st_col;
        logic        fin_v, run_start;
        t_token      fin_res;
        logic [34:0] prod;
        t_kw         kw;

        c        = i_char.char_code;
        eot      = i_char.end_of_text;
        is_let   = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
        is_dig   = c >= CH_0 && c <= CH_9;
        is_eq    = !eot && c == CH_EQ;
        col_inc  = (r_col != 16'hFFFF) ? r_col + 16'd1 : r_col;
        line_inc = (r_line != 16'hFFFF) ? r_line + 16'd1 : r_line;
        prod     = {4'b0, r_acc} * 35'd10 + {31'b0, c[3:0]};
        kw       = kw_lookup(r_buf, r_cnt);

        is_op   = 1'b0;
        op_code = TOK_END;
        for (int i = 0; i < NUM_OPS; i++) begin
            if (c == OP_CHARS[i]) begin
                is_op   = 1'b1;
                op_code = OP_CODES[i];
            end
        end

        // what the current character does when it opens a new token
        st_mode = M_START;
        st_v    = 1'b0;
        st_res  = '0;
        st_name = 1'b0;
        st_num  = 1'b0;
        st_rel  = 1'b0;
        st_line = r_line;
        st_col  = r_col;
        if (eot) begin
            st_col = col_inc;
            st_v   = 1'b1;
            st_res = make_tok(TOK_END, ERR_NONE, r_line, col_inc);
        end else if (is_let) begin
            st_col  = col_inc;
            st_name = 1'b1;
            st_mode = M_IDENT;
        end else if (is_dig) begin
            st_col  = col_inc;
            st_num  = 1'b1;
            st_mode = M_NUMBER;
        end else if (is_op) begin
            st_col = col_inc;
            st_v   = 1'b1;
            st_res = make_tok(op_code, ERR_NONE, r_line, col_inc);
        end else if (c == CH_EQ) begin
            st_col  = col_inc;
            st_mode = M_ASSIGN;
        end else if (c == CH_BANG) begin
            st_col  = col_inc;
            st_mode = M_BANG;
        end else if (c == CH_GT || c == CH_LT) begin
            st_col  = col_inc;
            st_rel  = 1'b1;
            st_mode = M_REL;
        end else if (c == CH_SP || c == CH_TAB) begin
            st_col = col_inc;
        end else if (c == CH_NL) begin
            st_col  = 16'd1;
            st_line = line_inc;
        end else begin
            st_mode = M_HALT;
            st_v    = 1'b1;
            st_res  = make_tok(TOK_END, ERR_BADCHAR, r_line, r_col);
        end

        n_mode    = r_mode;
        n_rel     = r_rel;
        n_buf     = r_buf;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_ovf     = r_ovf;
        n_line    = r_line;
        n_col     = r_col;
        fin_v     = 1'b0;
        fin_res   = '0;
        run_start = 1'b0;

        case (r_mode)
            M_START: begin
                run_start = 1'b1;
            end
            M_IDENT: begin
                if (!eot && (is_let || is_dig)) begin
                    if (r_cnt < 8'(NAME_CHARS)) begin
                        n_buf[8*r_cnt[2:0] +: 8] = c;
                    end
                    if (r_cnt != 8'hFF) begin
                        n_cnt = r_cnt + 8'd1;
                    end
                    n_col = col_inc;
                end else begin
                    fin_v = 1'b1;
                    if (kw.hit) begin
                        fin_res = make_tok(kw.code, ERR_NONE, r_line, r_col);
                    end else begin
                        fin_res                = make_tok(TOK_IDENT, ERR_NONE, r_line, r_col);
                        fin_res.name_text      = r_buf;
                        fin_res.name_length    = r_cnt;
                        fin_res.name_truncated = r_cnt > 8'(NAME_CHARS);
                    end
                    run_start = 1'b1;
                end
            end
            M_NUMBER: begin
                if (!eot && is_let) begin
                    fin_v   = 1'b1;
                    fin_res = make_tok(TOK_END, ERR_DIGLET, r_line, r_col);
                    n_mode  = M_HALT;
                end else if (!eot && is_dig) begin
                    if (prod[34:31] != 4'd0) begin
                        n_acc = MAX_VALUE;
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = prod[30:0];
                    end
                    n_col = col_inc;
                end else begin
                    fin_v                  = 1'b1;
                    fin_res                = make_tok(TOK_CONST, ERR_NONE, r_line, r_col);
                    fin_res.number_value   = r_acc;
                    fin_res.value_overflow = r_ovf;
                    run_start              = 1'b1;
                end
            end
            M_ASSIGN: begin
                fin_v = 1'b1;
                if (is_eq) begin
                    n_col   = col_inc;
                    n_mode  = M_START;
                    fin_res = make_tok(TOK_EQ, ERR_NONE, r_line, col_inc);
                end else begin
                    fin_res   = make_tok(TOK_ASSIGN, ERR_NONE, r_line, r_col);
                    run_start = 1'b1;
                end
            end
            M_BANG: begin
                fin_v = 1'b1;
                if (is_eq) begin
                    n_col   = col_inc;
                    n_mode  = M_START;
                    fin_res = make_tok(TOK_NE, ERR_NONE, r_line, col_inc);
                end else begin
                    n_mode  = M_HALT;
                    fin_res = make_tok(TOK_END, ERR_BANG, r_line, r_col);
                end
            end
            M_REL: begin
                fin_v = 1'b1;
                if (is_eq) begin
                    n_col   = col_inc;
                    n_mode  = M_START;
                    fin_res = make_tok(TOK_GE + {4'b0, r_rel}, ERR_NONE, r_line, col_inc);
                end else begin
                    fin_res   = make_tok(TOK_GT + {4'b0, r_rel}, ERR_NONE, r_line, r_col);
                    run_start = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (run_start) begin
            n_mode = st_mode;
            n_line = st_line;
            n_col  = st_col;
            if (st_name) begin
                n_buf = {56'b0, c};
                n_cnt = 8'd1;
            end
            if (st_num) begin
                n_acc = {27'b0, c[3:0]};
                n_ovf = 1'b0;
            end
            if (st_rel) begin
                n_rel = c == CH_LT;
            end
        end

        n_push.v0             = accept & (fin_v | (run_start & st_v));
        n_push.v1             = accept & fin_v & run_start & st_v;
        n_push.e0             = fin_v ? fin_res : st_res;
        n_push.e0.last_of_run = !(fin_v & run_start & st_v);
        n_push.e1             = st_res;
        n_push.e1.last_of_run = 1'b1;
    end

    assign o_push = n_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_START;
            r_rel  <= 1'b0;
            r_buf  <= '0;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
            r_line <= 16'd1;
            r_col  <= 16'd1;
        end else if (accept) begin
            r_mode <= n_mode;
            r_rel  <= n_rel;
            r_buf  <= n_buf;
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
            r_ovf  <= n_ovf;
            r_line <= n_line;
            r_col  <= n_col;
        end
    end

endmodule

`default_nettype wire

// ===== design/stt_queue.sv =====
// Token queue between scanner and output stage: two writes, one read per cycle.
// Uses stt_pkg for the token and push types.
`default_nettype none

module stt_queue
    import stt_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_push  i_push,
    input  wire logic   i_pop,
    output logic        o_room,
    output logic        o_valid,
    output t_token      o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_token          r_mem [DEPTH];
    logic [PW-1:0]   r_head, r_tail, n_head, n_tail, tail1;
    logic [CW-1:0]   r_count, n_count;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign tail1   = wrap_inc(r_tail);
    assign o_room  = r_count <= CW'(DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_head];

    always_comb begin
        n_head  = i_pop ? wrap_inc(r_head) : r_head;
        n_tail  = i_push.v1 ? wrap_inc(tail1) : (i_push.v0 ? tail1 : r_tail);
        n_count = r_count + CW'(i_push.v0) + CW'(i_push.v1) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_tail] <= i_push.e0;
        end
        if (i_push.v1) begin
            r_mem[tail1] <= i_push.e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== design/stt_emitter.sv =====
// Back end: output register that takes tokens off the queue and drives the
// token channel. Uses stt_pkg and stt_tok_if.
`default_nettype none

module stt_emitter
    import stt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_token  i_head,
    output logic         o_pop,
    stt_tok_if.source    o_tok
);

    logic   r_valid;
    t_token r_data;

    assign o_pop = i_valid & (!r_valid | o_tok.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_tok.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_head;
        end
    end

    assign o_tok.valid          = r_valid;
    assign o_tok.token_code     = r_data.token_code;
    assign o_tok.error_code     = r_data.error_code;
    assign o_tok.number_value   = r_data.number_value;
    assign o_tok.value_overflow = r_data.value_overflow;
    assign o_tok.name_text      = r_data.name_text;
    assign o_tok.name_length    = r_data.name_length;
    assign o_tok.name_truncated = r_data.name_truncated;
    assign o_tok.line_number    = r_data.line_number;
    assign o_tok.column_number  = r_data.column_number;
    assign o_tok.last_of_run    = r_data.last_of_run;

endmodule

`default_nettype wire

// ===== design/source_text_tokenizer.sv =====
// Top level of the source text tokenizer: scanner, token queue, output stage.
// Uses stt_pkg, stt_ifs, stt_scanner, stt_queue, stt_emitter.
//
// Usage:
//   i_char carries one source byte (char_code) or an end marker (end_of_text)
//   per beat. o_tok carries tokens; each input beat yields zero, one or two
//   tokens, and last_of_run marks the last token of a beat.
//   Throughput: one character per cycle while the queue has room; a beat that
//   yields two tokens still enters as one beat. The output side drains one
//   token per cycle while o_tok.ready is high; QUEUE_DEPTH sets how long a
//   burst can be absorbed. A finished token is written into the queue, then
//   registered in the output stage, then presented on o_tok. The scanner takes
//   a beat only while the queue has room for two tokens, so a stalled receiver
//   backs up into i_char.ready after the queue fills; no token is dropped.
//   After an error token the scanner keeps taking beats but yields nothing
//   until reset. Reset (synchronous, active low) returns the scanner to the
//   start state with line and column at 1 and empties the queue.
`default_nettype none

module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    stt_char_if.sink    i_char,
    stt_tok_if.source   o_tok
);

    t_push  push;
    logic   room;
    logic   q_valid;
    logic   pop;
    t_token head;

    stt_scanner u_scanner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_room  (room),
        .o_push  (push)
    );

    stt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_room  (room),
        .o_valid (q_valid),
        .o_head  (head)
    );

    stt_emitter u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_head  (head),
        .o_pop   (pop),
        .o_tok   (o_tok)
    );

endmodule

`default_nettype wire

// ===== design/stt_checker.sv =====
// Port-level checks on the token channel of the tokenizer, bound to the top.
// Uses stt_pkg for token and error codes.
`default_nettype none

module stt_checker
    import stt_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic [4:0]  i_token_code,
    input wire logic [1:0]  i_error_code,
    input wire logic [30:0] i_number_value,
    input wire logic [63:0] i_name_text,
    input wire logic [7:0]  i_name_length,
    input wire logic        i_name_truncated,
    input wire logic [15:0] i_line_number,
    input wire logic [15:0] i_column_number,
    input wire logic        i_last_of_run
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_token_code)
            && $stable(i_line_number) && $stable(i_column_number)
            && $stable(i_last_of_run))
        else $error("token beat changed while stalled");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_error_code != ERR_NONE |-> i_token_code == TOK_END
            && i_number_value == '0 && i_name_length == '0 && i_last_of_run)
        else $error("error token carries payload or is not last");

    a_name_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_token_code != TOK_IDENT |-> i_name_length == '0
            && i_name_text == '0 && !i_name_truncated)
        else $error("name fields set on non-identifier token");

    a_truncation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_name_truncated |-> i_name_length > 8'(NAME_CHARS))
        else $error("truncation flag with short name");

    a_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_line_number != '0 && i_column_number != '0)
        else $error("zero line or column");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_tok.valid),
    .i_ready          (o_tok.ready),
    .i_token_code     (o_tok.token_code),
    .i_error_code     (o_tok.error_code),
    .i_number_value   (o_tok.number_value),
    .i_name_text      (o_tok.name_text),
    .i_name_length    (o_tok.name_length),
    .i_name_truncated (o_tok.name_truncated),
    .i_line_number    (o_tok.line_number),
    .i_column_number  (o_tok.column_number),
    .i_last_of_run    (o_tok.last_of_run)
);

`default_nettype wire
